FILE: rtl/lda_pkg.sv
// Shared types, constants and tables for the lightning danger accumulator.
// No dependencies; every other file in rtl but lda_if uses this package.
`default_nettype none

package lda_pkg;

  localparam int MAX_BINS  = 16;
  localparam int ACC_W     = 32;
  localparam int CFG_W     = 16;
  localparam int SCORE_W   = 40;
  localparam int PROD_W    = ACC_W + CFG_W;
  localparam int PCT_W     = 7;
  localparam int KM_W      = 6;
  localparam int DIV_NUM_W = CFG_W + PCT_W;

  typedef logic [3:0]         bin_sel_t;
  typedef logic [ACC_W-1:0]   acc_t;
  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [CFG_W-1:0]   cfg_t;
  typedef logic [PCT_W-1:0]   pct_t;
  typedef logic [1:0]         cfg_idx_t;

  localparam cfg_idx_t CFG_DECAY      = 2'd0;
  localparam cfg_idx_t CFG_FLUSH      = 2'd1;
  localparam cfg_idx_t CFG_NEAREST    = 2'd2;
  localparam cfg_idx_t CFG_FULL_SCALE = 2'd3;

  localparam cfg_t DECAY_RESET      = 16'd64783;
  localparam cfg_t FLUSH_RESET      = 16'd66;
  localparam cfg_t NEAREST_RESET    = 16'd3277;
  localparam cfg_t FULL_SCALE_RESET = 16'd100;

  localparam acc_t ONE_Q16  = 32'h0001_0000;
  localparam acc_t ACC_MAX  = 32'hFFFF_FFFF;
  localparam logic [PROD_W-1:0] ROUND_HALF = 48'h0000_0000_8000;

  localparam logic [KM_W-1:0] KM_UNKNOWN_LO = 6'd0;
  localparam logic [KM_W-1:0] KM_UNKNOWN_HI = 6'd63;

  localparam pct_t PCT_LIMIT     = 7'd100;
  localparam pct_t PCT_ADVISORY  = 7'd5;
  localparam pct_t PCT_WARNING   = 7'd25;
  localparam pct_t PCT_DANGER    = 7'd50;
  localparam pct_t PCT_SEVERE    = 7'd75;

  localparam logic [2:0] LVL_SAFE     = 3'd0;
  localparam logic [2:0] LVL_ADVISORY = 3'd1;
  localparam logic [2:0] LVL_WARNING  = 3'd2;
  localparam logic [2:0] LVL_DANGER   = 3'd3;
  localparam logic [2:0] LVL_SEVERE   = 3'd4;

  localparam logic signed [6:0] NEAREST_NONE = -7'sd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STRIKE,
    S_DECAY_MUL,
    S_DECAY_WB,
    S_WEIGHT_ACC,
    S_SCALE,
    S_CLAMP,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    cfg_t                 den;
  } div_req_t;

  typedef struct packed {
    logic done;
    pct_t quot;
  } div_rsp_t;

  function automatic logic [4:0] bin_weight(bin_sel_t i);
    logic [4:0] w;
    case (i)
      4'd0:    w = 5'd20;
      4'd1:    w = 5'd16;
      4'd2:    w = 5'd10;
      4'd3:    w = 5'd6;
      4'd4:    w = 5'd4;
      4'd5:    w = 5'd2;
      default: w = 5'd1;
    endcase
    return w;
  endfunction

  function automatic logic [KM_W-1:0] bin_upper_km(bin_sel_t i);
    logic [KM_W-1:0] k;
    case (i)
      4'd0:    k = 6'd1;
      4'd1:    k = 6'd5;
      4'd2:    k = 6'd10;
      4'd3:    k = 6'd15;
      4'd4:    k = 6'd20;
      4'd5:    k = 6'd30;
      4'd6:    k = 6'd40;
      default: k = 6'd63;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lda_if.sv
// Valid/ready channel interfaces for strike/tick items and danger results.
// No dependencies; its field widths are literals that match lda_pkg.
`default_nettype none

interface lda_item_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [5:0] distance_km;

  modport source (output valid, func, distance_km, input ready);
  modport sink   (input valid, func, distance_km, output ready);
endinterface

interface lda_result_if;
  logic               valid;
  logic               ready;
  logic [39:0]        danger_score;
  logic [6:0]         danger_pct;
  logic [2:0]         level;
  logic signed [6:0]  nearest_km;

  modport source (output valid, danger_score, danger_pct, level, nearest_km, input ready);
  modport sink   (input valid, danger_score, danger_pct, level, nearest_km, output ready);
endinterface

`default_nettype wire

FILE: rtl/lda_mul.sv
// Shared 32 x 16 multiplier with registered product.
// Depends on lda_pkg.
`default_nettype none

module lda_mul (
  input  logic                  clk,
  input  lda_pkg::acc_t         a,
  input  lda_pkg::cfg_t         b,
  output logic [lda_pkg::PROD_W-1:0] prod
);
  import lda_pkg::*;

  always_ff @(posedge clk) begin
    prod <= {{CFG_W{1'b0}}, a} * {{ACC_W{1'b0}}, b};
  end

endmodule

`default_nettype wire

FILE: rtl/lda_div.sv
// Restoring divider, one quotient bit per cycle, seven-bit quotient.
// Depends on lda_pkg; the numerator must stay below 128 times the divisor.
`default_nettype none

module lda_div (
  input  logic              clk,
  input  logic              rst,
  input  lda_pkg::div_req_t req,
  output lda_pkg::div_rsp_t rsp
);
  import lda_pkg::*;

  logic                 busy;
  logic                 done;
  logic [2:0]           step;
  logic [DIV_NUM_W-1:0] rem;
  logic [DIV_NUM_W-1:0] dsr;
  pct_t                 quot;
  logic                 fits;

  assign fits = (rem >= dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 3'(PCT_W - 1);
      end else if (busy) begin
        step <= step - 3'd1;
        if (step == 3'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.num;
      dsr  <= {1'b0, req.den, {(PCT_W-1){1'b0}}};
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsr;
      end
      quot <= {quot[PCT_W-2:0], fits};
      dsr  <= dsr >> 1;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

`default_nettype wire

FILE: rtl/lightning_danger_accumulator.sv
// Lightning danger accumulator top level: sequencer, bin registers, output register.
// Depends on lda_pkg, lda_if, lda_mul and lda_div.
//
// A strike beat (func 0) adds 1.0 to its distance bin and delivers no result. A tick
// beat (func 1) decays every bin, finds the nearest active bin, forms the weighted score
// and the percentage, and delivers one result beat. Each bin uses the shared multiplier
// twice (decay product, then weight product), and the percentage comes from a serial
// divide unless it is clamped at the limit. Input is ready only while the sequencer is
// idle; a finished result waits in the output register, so strikes are taken while it
// is pending. Configuration writes take effect at once and belong in idle periods.
`default_nettype none

module lightning_danger_accumulator #(
  parameter int NUM_BINS = 8
) (
  input  logic                clk,
  input  logic                rst,
  lda_item_if.sink            item,
  lda_result_if.source        result,
  input  logic                cfg_we,
  input  lda_pkg::cfg_idx_t   cfg_index,
  input  lda_pkg::cfg_t       cfg_data
);
  import lda_pkg::*;

  localparam int IW = $clog2(NUM_BINS);
  localparam logic [IW-1:0] LAST_BIN = IW'(NUM_BINS - 1);
  localparam logic [IW-1:0] FAR_BIN  = IW'(NUM_BINS - 2);

  state_t state, state_next;

  acc_t               acc [NUM_BINS];
  logic [IW-1:0]      idx;
  logic [IW-1:0]      strike_bin;
  score_t             score;
  logic signed [6:0]  nearest;
  logic [PROD_W-1:0]  scaled;
  pct_t               pct;

  cfg_t decay_factor, flush_level, nearest_level, full_scale;
  cfg_t fs;

  acc_t              mul_a;
  cfg_t              mul_b;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rounded;
  acc_t              a_new;
  logic [SCORE_W:0]  score_sum;
  logic [31:0]       pct_num;
  logic [31:0]       fs101;
  logic              clamp;
  logic [KM_W-1:0]   bin_km;
  logic [2:0]        level_now;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              res_valid;
  score_t            res_score;
  pct_t              res_pct;
  logic [2:0]        res_level;
  logic signed [6:0] res_nearest;

  logic item_beat;
  logic out_free;

  lda_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  lda_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_factor  <= DECAY_RESET;
      flush_level   <= FLUSH_RESET;
      nearest_level <= NEAREST_RESET;
      full_scale    <= FULL_SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DECAY:      decay_factor  <= cfg_data;
        CFG_FLUSH:      flush_level   <= cfg_data;
        CFG_NEAREST:    nearest_level <= cfg_data;
        CFG_FULL_SCALE: full_scale    <= cfg_data;
        default:        ;
      endcase
    end
  end

  assign fs = (full_scale == '0) ? 16'd1 : full_scale;

  always_comb begin
    strike_bin = FAR_BIN;
    for (int i = NUM_BINS - 2; i >= 0; i--) begin
      if (item.distance_km <= bin_upper_km(bin_sel_t'(i))) begin
        strike_bin = IW'(i);
      end
    end
    if (item.distance_km == KM_UNKNOWN_LO || item.distance_km == KM_UNKNOWN_HI) begin
      strike_bin = LAST_BIN;
    end
  end

  assign item_beat = item.valid && item.ready;
  assign out_free  = !res_valid || result.ready;

  assign rounded   = prod + ROUND_HALF;
  assign a_new     = (rounded[PROD_W-1:CFG_W] < {{(ACC_W-CFG_W){1'b0}}, flush_level})
                     ? '0 : rounded[PROD_W-1:CFG_W];
  assign score_sum = {1'b0, score} + {1'b0, prod[SCORE_W-1:0]};
  assign bin_km    = bin_upper_km(bin_sel_t'(idx));
  assign pct_num   = scaled[PROD_W-1:CFG_W];
  assign fs101     = (32'(fs) << 6) + (32'(fs) << 5) + (32'(fs) << 2) + 32'(fs);
  assign clamp     = (pct_num >= fs101);

  always_comb begin
    if (pct < PCT_ADVISORY)     level_now = LVL_SAFE;
    else if (pct < PCT_WARNING) level_now = LVL_ADVISORY;
    else if (pct < PCT_DANGER)  level_now = LVL_WARNING;
    else if (pct < PCT_SEVERE)  level_now = LVL_DANGER;
    else                        level_now = LVL_SEVERE;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_beat) state_next = item.func ? S_DECAY_MUL : S_STRIKE;
      end
      S_STRIKE:     state_next = S_IDLE;
      S_DECAY_MUL:  state_next = S_DECAY_WB;
      S_DECAY_WB:   state_next = S_WEIGHT_ACC;
      S_WEIGHT_ACC: state_next = (idx == LAST_BIN) ? S_SCALE : S_DECAY_MUL;
      S_SCALE:      state_next = S_CLAMP;
      S_CLAMP:      state_next = clamp ? S_DONE : S_DIV;
      S_DIV: begin
        if (div_rsp.done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default:      state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item.ready    = 1'b0;
    mul_a         = acc[idx];
    mul_b         = decay_factor;
    div_req.start = 1'b0;
    div_req.num   = pct_num[DIV_NUM_W-1:0];
    div_req.den   = fs;
    unique case (state)
      S_IDLE:     item.ready = 1'b1;
      S_DECAY_WB: begin
        mul_a = a_new;
        mul_b = {{(CFG_W-5){1'b0}}, bin_weight(bin_sel_t'(idx))};
      end
      S_CLAMP:    div_req.start = !clamp;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BINS; i++) acc[i] <= '0;
      idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_beat) idx <= item.func ? '0 : strike_bin;
        end
        S_STRIKE: begin
          acc[idx] <= (acc[idx] > ACC_MAX - ONE_Q16) ? ACC_MAX : acc[idx] + ONE_Q16;
        end
        S_DECAY_WB:   acc[idx] <= a_new;
        S_WEIGHT_ACC: begin
          if (idx != LAST_BIN) idx <= idx + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        score   <= '0;
        nearest <= NEAREST_NONE;
      end
      S_DECAY_WB: begin
        if (idx != LAST_BIN && a_new > {{(ACC_W-CFG_W){1'b0}}, nearest_level} &&
            (nearest < 0 || $signed({1'b0, bin_km}) < nearest)) begin
          nearest <= $signed({1'b0, bin_km});
        end
      end
      S_WEIGHT_ACC: score <= score_sum[SCORE_W] ? '1 : score_sum[SCORE_W-1:0];
      S_SCALE: begin
        scaled <= ({{(PROD_W-SCORE_W){1'b0}}, score} << 6)
                + ({{(PROD_W-SCORE_W){1'b0}}, score} << 5)
                + ({{(PROD_W-SCORE_W){1'b0}}, score} << 2)
                + {{(PROD_W-CFG_W-15){1'b0}}, fs, 15'b0};
      end
      S_CLAMP: begin
        if (clamp) pct <= PCT_LIMIT;
      end
      S_DIV: begin
        if (div_rsp.done) pct <= div_rsp.quot;
      end
      default: ;
    endcase
  end

  // hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      res_score   <= score;
      res_pct     <= pct;
      res_level   <= level_now;
      res_nearest <= nearest;
    end
  end

  assign result.valid        = res_valid;
  assign result.danger_score = res_score;
  assign result.danger_pct   = res_pct;
  assign result.level        = res_level;
  assign result.nearest_km   = res_nearest;

`ifndef SYNTH
  a_strike_next: assert property (@(posedge clk) disable iff (rst)
    item_beat && !item.func |=> state == S_STRIKE)
    else $error("strike beat did not enter update");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside divide step");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= LAST_BIN)
    else $error("bin index out of range");

  a_level_pct: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_pct <= PCT_LIMIT) &&
                  ((res_level == LVL_SEVERE) == (res_pct >= PCT_SEVERE)))
    else $error("result level does not match percentage");
`endif

endmodule

`default_nettype wire
